@@ src/cpt_pkg.sv @@
// shared types and constants of the contact pair tracker
package cpt_pkg;

  localparam int FIELD_BITS = 16;
  localparam int KIND_BITS  = 2;
  localparam int LIMIT_BITS = 8;
  localparam int MAX_RESULTS = 64;
  localparam int N_BITS = $clog2(MAX_RESULTS + 1);

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd128;
  localparam logic [LIMIT_BITS-1:0] COUNT_MAX   = 8'hFF;

  // result kinds
  localparam logic [KIND_BITS-1:0] EV_ENTER     = 2'd0;
  localparam logic [KIND_BITS-1:0] EV_STAY      = 2'd1;
  localparam logic [KIND_BITS-1:0] EV_EXIT      = 2'd2;
  localparam logic [KIND_BITS-1:0] EV_FRAME_END = 2'd3;

  // table write selects
  typedef logic [2:0] wr_sel_t;
  localparam wr_sel_t WR_NONE   = 3'd0;
  localparam wr_sel_t WR_CLEAR  = 3'd1;
  localparam wr_sel_t WR_SEEN   = 3'd2;
  localparam wr_sel_t WR_UNSEEN = 3'd3;
  localparam wr_sel_t WR_REMOVE = 3'd4;
  localparam wr_sel_t WR_INSERT = 3'd5;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    wr_sel_t wr;
    logic    idx_inc;
    logic    look_free;
    logic    set_stay;
    logic    emit_contact;
    logic    exit_take;
    logic    sweep_end;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic null_id;
    logic rd_valid;
    logic rd_seen;
    logic rd_match;
    logic idx_last;
    logic free_found;
    logic out_free;
    logic hold_valid;
    logic n_full;
  } status_t;

endpackage

@@ src/contact_pair_enter_stay_exit_tracker.sv @@
// top level of the contact pair enter/stay/exit tracker
//
//  channel  signals                             direction
//  in       in_valid, in_stall, func, body_a/b  request in, stall out
//  out      out_valid, out_stall, event fields  request out, stall in
//  cfg      cfg_write, cfg_data                 write only, event_limit
//
// a contact scans the pair table slot by slot (single port, registered read),
// reading and then checking each slot: a hit stops the scan, a miss scans every slot
// a null id skips the scan; an end of step sweeps every slot and waits on output stalls
// after reset a clearing pass over every slot holds in_stall high
// a stalled output holds its result; the next exit waits for the output register
module contact_pair_enter_stay_exit_tracker #(
  parameter int TABLE_DEPTH = 64,
  parameter int ID_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  logic [cpt_pkg::FIELD_BITS-1:0]  body_a,
  input  logic [cpt_pkg::FIELD_BITS-1:0]  body_b,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cpt_pkg::KIND_BITS-1:0]   event_kind,
  output logic [cpt_pkg::FIELD_BITS-1:0]  body_low,
  output logic [cpt_pkg::FIELD_BITS-1:0]  body_high,
  output logic                            recorded,
  output logic                            table_full,
  output logic                            last,
  input  logic                            cfg_write,
  input  logic [cpt_pkg::LIMIT_BITS-1:0]  cfg_data
);
  import cpt_pkg::*;

  cmd_t    cmd;
  status_t status;

  cpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cpt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .func       (func),
    .body_a     (body_a),
    .body_b     (body_b),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .body_low   (body_low),
    .body_high  (body_high),
    .recorded   (recorded),
    .table_full (table_full),
    .last       (last)
  );

  // an accepted end of step always starts a sweep
  a_step_sweeps: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func |=> in_stall)
    else $error("end of step did not start a sweep");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_FRAME_END |-> last && !recorded && !table_full)
    else $error("frame end result malformed");

  a_contact_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_ENTER || event_kind == EV_STAY) |-> last)
    else $error("contact result without last");

  a_full_enter: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> event_kind == EV_ENTER)
    else $error("table full flag on a non-enter result");

endmodule

@@ src/cpt_dp.sv @@
// datapath of the contact pair tracker: pair table, counters, output register
module cpt_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int ID_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cpt_pkg::cmd_t                   cmd,
  output cpt_pkg::status_t                status,
  input  logic                            func,
  input  logic [cpt_pkg::FIELD_BITS-1:0]  body_a,
  input  logic [cpt_pkg::FIELD_BITS-1:0]  body_b,
  input  logic                            cfg_write,
  input  logic [cpt_pkg::LIMIT_BITS-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cpt_pkg::KIND_BITS-1:0]   event_kind,
  output logic [cpt_pkg::FIELD_BITS-1:0]  body_low,
  output logic [cpt_pkg::FIELD_BITS-1:0]  body_high,
  output logic                            recorded,
  output logic                            table_full,
  output logic                            last
);
  import cpt_pkg::*;

  localparam int IDX_BITS   = $clog2(TABLE_DEPTH);
  localparam int KEY_BITS   = 2 * ID_BITS;
  localparam int ENTRY_BITS = KEY_BITS + 2;
  localparam int EXT_BITS   = ID_BITS + FIELD_BITS;

  function automatic logic [ID_BITS-1:0] to_id(input logic [FIELD_BITS-1:0] v);
    logic [EXT_BITS-1:0] ext;
    ext = EXT_BITS'(v);
    return ext[ID_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(input logic [ID_BITS-1:0] v);
    logic [EXT_BITS-1:0] ext;
    ext = EXT_BITS'(v);
    return ext[FIELD_BITS-1:0];
  endfunction

  // table entry: valid, seen, key
  logic [ENTRY_BITS-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_BITS-1:0] rdata;
  logic [ENTRY_BITS-1:0] wdata;
  logic [IDX_BITS-1:0]   waddr;
  logic                  we;

  logic [IDX_BITS-1:0]   idx;
  logic [IDX_BITS-1:0]   free_idx;
  logic                  free_found;
  logic [ID_BITS-1:0]    in_lo;
  logic [ID_BITS-1:0]    in_hi;
  logic [KIND_BITS-1:0]  kind;
  logic [LIMIT_BITS-1:0] limit;
  logic [LIMIT_BITS-1:0] count;
  logic [N_BITS-1:0]     n;
  logic                  hold_valid;
  logic [ID_BITS-1:0]    hold_lo;
  logic [ID_BITS-1:0]    hold_hi;
  logic                  hold_rec;

  logic [ID_BITS-1:0]    a_id;
  logic [ID_BITS-1:0]    b_id;
  logic [KEY_BITS-1:0]   in_key;
  logic [KEY_BITS-1:0]   rd_key;
  logic                  rd_valid;
  logic                  rec_now;
  logic                  take;
  logic                  out_free;

  assign a_id     = to_id(body_a);
  assign b_id     = to_id(body_b);
  assign in_key   = {in_lo, in_hi};
  assign rd_key   = rdata[KEY_BITS-1:0];
  assign rd_valid = rdata[ENTRY_BITS-1];
  assign rec_now  = count < limit;
  assign take     = cmd.emit_contact | cmd.exit_take;
  assign out_free = !out_valid || !out_stall;

  assign status.func       = func;
  assign status.null_id    = (a_id == '0) || (b_id == '0);
  assign status.rd_valid   = rd_valid;
  assign status.rd_seen    = rdata[ENTRY_BITS-2];
  assign status.rd_match   = rd_key == in_key;
  assign status.idx_last   = idx == IDX_BITS'(TABLE_DEPTH - 1);
  assign status.free_found = free_found;
  assign status.out_free   = out_free;
  assign status.hold_valid = hold_valid;
  assign status.n_full     = n == N_BITS'(MAX_RESULTS);

  always_comb begin
    we    = 1'b1;
    waddr = idx;
    wdata = '0;
    unique case (cmd.wr)
      WR_CLEAR, WR_REMOVE: wdata = '0;
      WR_SEEN:             wdata = {2'b11, in_key};
      WR_UNSEEN:           wdata = {2'b10, rd_key};
      WR_INSERT: begin
        wdata = {2'b11, in_key};
        waddr = free_idx;
      end
      default:             we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[idx];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      free_found <= 1'b0;
      limit      <= LIMIT_RESET;
      count      <= '0;
      n          <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        limit <= cfg_data;
      end
      if (cmd.accept) begin
        idx        <= '0;
        free_found <= 1'b0;
        n          <= '0;
        hold_valid <= 1'b0;
      end else begin
        if (cmd.idx_inc) begin
          idx <= idx + 1'b1;
        end
        if (cmd.look_free && !rd_valid && !free_found) begin
          free_found <= 1'b1;
        end
        if (cmd.exit_take) begin
          n          <= n + 1'b1;
          hold_valid <= 1'b1;
        end
        if (cmd.sweep_end) begin
          hold_valid <= 1'b0;
        end
      end
      if (take && count != COUNT_MAX) begin
        count <= count + 1'b1;
      end
      if (cmd.sweep_end) begin
        count <= '0;
      end
      if (cmd.emit_contact || cmd.sweep_end || (cmd.exit_take && hold_valid)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind <= EV_ENTER;
      if (a_id < b_id) begin
        in_lo <= a_id;
        in_hi <= b_id;
      end else begin
        in_lo <= b_id;
        in_hi <= a_id;
      end
    end
    if (cmd.set_stay) begin
      kind <= EV_STAY;
    end
    if (cmd.look_free && !rd_valid && !free_found) begin
      free_idx <= idx;
    end
    if (cmd.exit_take) begin
      hold_lo  <= rd_key[KEY_BITS-1:ID_BITS];
      hold_hi  <= rd_key[ID_BITS-1:0];
      hold_rec <= rec_now;
    end
    if (cmd.emit_contact) begin
      event_kind <= kind;
      body_low   <= to_field(in_lo);
      body_high  <= to_field(in_hi);
      recorded   <= rec_now;
      table_full <= (kind == EV_ENTER) && !free_found;
      last       <= 1'b1;
    end else if (cmd.exit_take && hold_valid) begin
      event_kind <= EV_EXIT;
      body_low   <= to_field(hold_lo);
      body_high  <= to_field(hold_hi);
      recorded   <= hold_rec;
      table_full <= 1'b0;
      last       <= 1'b0;
    end else if (cmd.sweep_end) begin
      table_full <= 1'b0;
      last       <= 1'b1;
      if (hold_valid) begin
        event_kind <= EV_EXIT;
        body_low   <= to_field(hold_lo);
        body_high  <= to_field(hold_hi);
        recorded   <= hold_rec;
      end else begin
        event_kind <= EV_FRAME_END;
        body_low   <= '0;
        body_high  <= '0;
        recorded   <= 1'b0;
      end
    end
  end

endmodule

@@ src/cpt_ctrl.sv @@
// controller state machine of the contact pair tracker
module cpt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  cpt_pkg::status_t status,
  output cpt_pkg::cmd_t    cmd
);
  import cpt_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LK_RD  = 4'd2;
  localparam logic [3:0] S_LK_EV  = 4'd3;
  localparam logic [3:0] S_INS    = 4'd4;
  localparam logic [3:0] S_EMIT   = 4'd5;
  localparam logic [3:0] S_SW_RD  = 4'd6;
  localparam logic [3:0] S_SW_EV  = 4'd7;
  localparam logic [3:0] S_SW_END = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       sweep_adv;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.wr     = WR_NONE;
    state_next = state;
    sweep_adv  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.wr      = WR_CLEAR;
        cmd.idx_inc = 1'b1;
        if (status.idx_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.func) begin
            state_next = S_SW_RD;
          end else if (!status.null_id) begin
            state_next = S_LK_RD;
          end
        end
      end
      S_LK_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LK_EV;
      end
      S_LK_EV: begin
        if (status.rd_valid && status.rd_match) begin
          cmd.wr       = WR_SEEN;
          cmd.set_stay = 1'b1;
          state_next   = S_EMIT;
        end else begin
          cmd.look_free = 1'b1;
          if (status.idx_last) begin
            state_next = S_INS;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_LK_RD;
          end
        end
      end
      S_INS: begin
        if (status.free_found) begin
          cmd.wr = WR_INSERT;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_contact = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_SW_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SW_EV;
      end
      S_SW_EV: begin
        priority if (status.rd_valid && status.rd_seen) begin
          cmd.wr    = WR_UNSEEN;
          sweep_adv = 1'b1;
        end else if (status.rd_valid && status.n_full) begin
          cmd.wr    = WR_REMOVE;
          sweep_adv = 1'b1;
        end else if (status.rd_valid) begin
          // a held exit must leave before the next one replaces it
          if (!status.hold_valid || status.out_free) begin
            cmd.wr        = WR_REMOVE;
            cmd.exit_take = 1'b1;
            sweep_adv     = 1'b1;
          end
        end else begin
          sweep_adv = 1'b1;
        end
        if (sweep_adv) begin
          if (status.idx_last) begin
            state_next = S_SW_END;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_SW_RD;
          end
        end
      end
      S_SW_END: begin
        if (status.out_free) begin
          cmd.sweep_end = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
